@@ rtl/core/crk_pkg.sv @@
// Shared types and constants for the competition rank engine.
// Used by every module under rtl/core; depends on nothing.
package crk_pkg;

    // Key width and rank width are fixed by the item formats
    localparam int KEY_W           = 48;
    localparam int RANK_W          = 7;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // One input row as it arrives on the item channel
    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic                    key_present;
        logic                    key_is_nan;
        logic                    last_item;
    } crk_in_t;

    // One result as it leaves on the result channel
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              rank_present;
        logic              last_rank;
    } crk_out_t;

    // Classified row travelling from the front end to the back end
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    present;
        logic                    nan;
        logic                    last;
    } crk_entry_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_LOAD,
        BK_FETCH,
        BK_SCAN,
        BK_DRAIN,
        BK_EMIT
    } crk_back_state_t;

endpackage

@@ rtl/core/crk_front.sv @@
// Front end: accepts item transactions and classifies each row.
// Depends on crk_pkg for the item and queue entry types.
module crk_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  crk_pkg::crk_in_t    item_data,
    output logic                push_valid,
    input  logic                push_ready,
    output crk_pkg::crk_entry_t push_data
);
    import crk_pkg::*;

    crk_entry_t entry_reg;
    crk_entry_t entry_next;
    logic       valid_reg;
    logic       valid_next;
    logic       accept;
    logic       pushed;

    // Hold the row while the queue is full
    assign item_stall = valid_reg && !push_ready;
    assign accept     = item_valid && !item_stall;
    assign pushed     = valid_reg && push_ready;
    assign push_valid = valid_reg;
    assign push_data  = entry_reg;

    // Classify: absent beats NaN, and only plain numbers keep their key
    always_comb
    begin
        entry_next.present = item_data.key_present;
        entry_next.nan     = item_data.key_present && item_data.key_is_nan;
        entry_next.last    = item_data.last_item;
        if (item_data.key_present && !item_data.key_is_nan)
        begin
            entry_next.key = item_data.key_value;
        end
        else
        begin
            entry_next.key = '0;
        end
    end

    // Advance the holding register
    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (pushed)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    // A held row must not be replaced before it has gone to the queue
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !push_ready) |=> valid_reg)
        else $error("front row dropped while queue full");
    // Absent rows never reach the queue marked as NaN
    a_absent_not_nan: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (entry_reg.present || !entry_reg.nan))
        else $error("absent row classified as NaN");
    // Only plain numbers carry a non-zero key
    a_key_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (!entry_reg.present || entry_reg.nan)) |-> (entry_reg.key == '0))
        else $error("non-number row carries a key");

endmodule

@@ rtl/core/crk_queue.sv @@
// Short FIFO of classified rows between the front and back ends.
// Depends on crk_pkg for the queue entry type and default depth.
module crk_queue #(
    parameter int DEPTH = crk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  crk_pkg::crk_entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output crk_pkg::crk_entry_t pop_data
);
    import crk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crk_entry_t             slots [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push_fire;
    logic                   pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed row
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy lost a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

@@ rtl/core/crk_back.sv @@
// Back end: stores the column, ranks each stored row by a sweep over the
// store and drives the result register. Depends on crk_pkg.
module crk_back #(
    parameter int MAX_ITEMS = crk_pkg::MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                descending,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  crk_pkg::crk_entry_t pop_data,
    output logic                result_valid,
    input  logic                result_stall,
    output crk_pkg::crk_out_t   result_data
);
    import crk_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    // Column store: one write port, two registered read ports
    logic signed [KEY_W-1:0] key_mem  [MAX_ITEMS];
    logic [1:0]              flag_mem [MAX_ITEMS];

    crk_back_state_t         state_reg;
    crk_back_state_t         state_next;
    logic [CNT_W-1:0]        load_cnt_reg;
    logic [CNT_W-1:0]        load_cnt_next;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        n_next;
    logic [IDX_W-1:0]        i_reg;
    logic [IDX_W-1:0]        i_next;
    logic [IDX_W-1:0]        j_reg;
    logic [IDX_W-1:0]        j_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    cmp_valid_reg;
    logic                    cmp_valid_next;
    logic [IDX_W-1:0]        cmp_j_reg;
    logic signed [KEY_W-1:0] ki_reg;
    logic [1:0]              fi_reg;
    logic signed [KEY_W-1:0] kj_reg;
    logic [1:0]              fj_reg;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    crk_out_t                result_reg;
    crk_out_t                result_next;

    logic                    pop_fire;
    logic                    room;
    logic                    mem_we;
    logic                    out_load;
    logic                    out_free;
    logic                    scan_end;
    logic                    emit_end;
    logic                    precedes;

    assign pop_fire     = pop_valid && pop_ready;
    assign room         = (load_cnt_reg < CNT_W'(MAX_ITEMS));
    assign out_free     = !result_valid_reg || !result_stall;
    assign scan_end     = ((CNT_W'(j_reg) + 1'b1) == n_reg);
    assign emit_end     = ((CNT_W'(i_reg) + 1'b1) == n_reg);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // Does stored row j come before row i in the chosen order
    always_comb
    begin
        precedes = 1'b0;
        if (fj_reg[0])
        begin
            if (fi_reg[1])
            begin
                precedes = fj_reg[1] ? (cmp_j_reg < i_reg) : !descending;
            end
            else if (fj_reg[1])
            begin
                precedes = descending;
            end
            else
            begin
                precedes = descending ? (kj_reg > ki_reg) : (kj_reg < ki_reg);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (pop_fire && pop_data.last)
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_SCAN;
            end
            BK_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = emit_end ? BK_LOAD : BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        pop_ready = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_LOAD:
            begin
                pop_ready = 1'b1;
                mem_we    = pop_valid && room;
            end
            BK_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        load_cnt_next  = load_cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        cmp_valid_next = (state_reg == BK_SCAN);

        // Load: count stored rows, close the column on the last one
        if (mem_we)
        begin
            load_cnt_next = load_cnt_reg + 1'b1;
        end
        if (pop_fire && pop_data.last)
        begin
            n_next        = mem_we ? load_cnt_reg + 1'b1 : load_cnt_reg;
            load_cnt_next = '0;
            i_next        = '0;
        end

        // Sweep: restart per row, step the read address
        if (state_reg == BK_FETCH)
        begin
            j_next   = '0;
            cnt_next = '0;
        end
        else if (state_reg == BK_SCAN)
        begin
            j_next = j_reg + 1'b1;
        end
        if (cmp_valid_reg && precedes)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (out_load)
        begin
            i_next = i_reg + 1'b1;
        end

        // Result register
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (out_load)
        begin
            result_valid_next        = 1'b1;
            result_next.rank_present = fi_reg[0];
            result_next.rank         = fi_reg[0] ? RANK_W'(cnt_reg) + 1'b1 : '0;
            result_next.last_rank    = emit_end;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_LOAD;
            load_cnt_reg     <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            cnt_reg          <= '0;
            cmp_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_cnt_reg     <= load_cnt_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            cnt_reg          <= cnt_next;
            cmp_valid_reg    <= cmp_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_j_reg  <= j_reg;
        result_reg <= result_next;
    end

    // Column store: write on load, read row i and row j every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[load_cnt_reg[IDX_W-1:0]]  <= pop_data.key;
            flag_mem[load_cnt_reg[IDX_W-1:0]] <= {pop_data.nan, pop_data.present};
        end
        ki_reg <= key_mem[i_reg];
        fi_reg <= flag_mem[i_reg];
        kj_reg <= key_mem[j_reg];
        fj_reg <= flag_mem[j_reg];
    end

    a_batch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_LOAD) |-> (n_reg != '0))
        else $error("ranking an empty column");
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (CNT_W'(i_reg) < n_reg))
        else $error("result index beyond stored rows");
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_end) |=> (state_reg == BK_LOAD))
        else $error("final result did not return to loading");
    a_no_pop_while_ranking: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_LOAD) |-> !pop_ready)
        else $error("queue popped during ranking");

endmodule

@@ rtl/core/competition_rank_engine.sv @@
// Top level of the competition rank engine: config register and the
// front end, queue and back end. Depends on crk_pkg, crk_front, crk_queue, crk_back.

// Loads one column of up to MAX_ITEMS rows, one item transaction per cycle,
// and after the row marked last_item returns one result transaction per
// stored row in load order, carrying its competition ("1224") rank; absent
// rows give rank 0 with rank_present low, rows beyond MAX_ITEMS are dropped.
// NaN rows sort after all numbers (before them when descending) in load
// order and never tie. Each rank is found by sweeping the stored column
// through the back end's second memory read port, one row per cycle.
// Rows keep loading at one per cycle into the QUEUE_DEPTH-entry queue
// and the front register while a batch is being ranked; then the item
// channel stalls. The descending bit is sampled while ranks are produced,
// so write it only between batches.
module competition_rank_engine #(
    parameter int MAX_ITEMS   = crk_pkg::MAX_ITEMS_DEF,
    parameter int QUEUE_DEPTH = crk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  crk_pkg::crk_in_t  item_data,
    output logic              result_valid,
    input  logic              result_stall,
    output crk_pkg::crk_out_t result_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import crk_pkg::*;

    logic       descending_reg;
    logic       push_valid;
    logic       push_ready;
    crk_entry_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    crk_entry_t pop_data;

    // Configuration: always ready, single register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            descending_reg <= cfg_data;
        end
    end

    crk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    crk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    crk_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .descending   (descending_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

@@ bench/competition_rank_engine_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for competition_rank_engine: directed and random columns,
// ranks predicted inside the bench and compared per result transaction.
// Depends on crk_pkg and the competition_rank_engine RTL.
module competition_rank_engine_test;
    import crk_pkg::*;

    localparam int ROW_SLOTS     = MAX_ITEMS_DEF;
    localparam int QUIET_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = 100;
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_ONE = 48'sh1_0000;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_stall;
    crk_in_t  item_data;
    logic     result_valid;
    logic     result_stall;
    crk_out_t result_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    // Column held by the rank predictor
    logic signed [KEY_W-1:0] held_key [ROW_SLOTS];
    logic                    held_present [ROW_SLOTS];
    logic                    held_nan [ROW_SLOTS];
    int                      held_rows;
    logic                    rank_descending;

    crk_out_t expected_ranks [$];
    int       mismatches;
    bit       idling;
    int       quiet_cycles = 0;

    competition_rank_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rank one held row: one more than the rows that sort strictly ahead of it
    function automatic logic [RANK_W-1:0] competition_rank(input int row);
        int ahead;
        ahead = 0;
        for (int j = 0; j < held_rows; j++)
        begin
            if (!held_present[j])
                continue;
            if (held_nan[row])
            begin
                // NaN rows never tie: earlier NaNs go first, numbers first unless descending
                if (held_nan[j])
                begin
                    if (j < row)
                        ahead++;
                end
                else if (!rank_descending)
                    ahead++;
            end
            else if (held_nan[j])
            begin
                if (rank_descending)
                    ahead++;
            end
            else if (rank_descending ? (held_key[j] > held_key[row])
                                     : (held_key[j] < held_key[row]))
                ahead++;
        end
        return RANK_W'(ahead + 1);
    endfunction

    // Hold an accepted row; on the last row queue one rank per held row
    function automatic void absorb_row(input crk_in_t row);
        crk_out_t ranked;
        if (held_rows < ROW_SLOTS)
        begin
            held_key[held_rows]     = row.key_value;
            held_present[held_rows] = row.key_present;
            held_nan[held_rows]     = row.key_present && row.key_is_nan;
            held_rows++;
        end
        if (row.last_item)
        begin
            for (int i = 0; i < held_rows; i++)
            begin
                ranked.rank         = held_present[i] ? competition_rank(i) : '0;
                ranked.rank_present = held_present[i];
                ranked.last_rank    = (i == held_rows - 1);
                expected_ranks      = {expected_ranks, ranked};
            end
            held_rows = 0;
        end
    endfunction

    function automatic crk_in_t build_row(input logic signed [KEY_W-1:0] key,
                                          input logic present, input logic nan,
                                          input logic last);
        crk_in_t row;
        row.key_value   = key;
        row.key_present = present;
        row.key_is_nan  = nan;
        row.last_item   = last;
        return row;
    endfunction

    // Mostly tie-heavy small keys, with full-width and extreme keys mixed in
    function automatic crk_in_t random_row(input logic last);
        crk_in_t row;
        int      pick;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                pick          = $urandom_range(0, 6) - 3;
                row.key_value = KEY_ONE * pick;
            end
            4, 5:
                row.key_value = KEY_W'({$urandom(), $urandom()});
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       row.key_value = KEY_MIN;
                    1:       row.key_value = KEY_MAX;
                    2:       row.key_value = '0;
                    default: row.key_value = '1;
                endcase
            end
            default:
            begin
                pick          = $urandom_range(0, 15) - 8;
                row.key_value = KEY_W'(pick);
            end
        endcase
        row.key_present = ($urandom_range(0, 9) != 0);
        row.key_is_nan  = ($urandom_range(0, 7) == 0);
        row.last_item   = last;
        return row;
    endfunction

    // Send one row transaction, with an optional idle burst ahead of it
    task automatic send_row(input crk_in_t row);
        int gap;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            gap        = $urandom_range(1, 15);
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid = 1'b1;
        item_data  = row;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_row(row);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (expected_ranks.size() != 0)
            @(negedge clk);
    endtask

    // Write the order bit only once every batch has been ranked and drained
    task automatic write_descending(input logic desc);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = desc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rank_descending = desc;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_ascending_extremes();
        write_descending(1'b0);
        send_row(build_row(KEY_MAX, 1'b1, 1'b0, 1'b0));
        send_row(build_row(KEY_MIN, 1'b1, 1'b0, 1'b0));
        send_row(build_row('0, 1'b1, 1'b0, 1'b0));
        send_row(build_row(KEY_ONE, 1'b1, 1'b1, 1'b0));
        // absent wins over the NaN flag
        send_row(build_row(KEY_MAX, 1'b0, 1'b1, 1'b0));
        send_row(build_row('0, 1'b1, 1'b0, 1'b0));
        send_row(build_row('1, 1'b1, 1'b0, 1'b0));
        send_row(build_row(KEY_MIN, 1'b1, 1'b1, 1'b0));
        send_row(build_row(KEY_MAX, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_descending_extremes();
        write_descending(1'b1);
        send_row(build_row(KEY_MIN, 1'b1, 1'b0, 1'b0));
        send_row(build_row('1, 1'b1, 1'b1, 1'b0));
        send_row(build_row(KEY_MAX, 1'b1, 1'b0, 1'b0));
        send_row(build_row(KEY_ONE, 1'b0, 1'b0, 1'b0));
        send_row(build_row(KEY_MAX, 1'b1, 1'b0, 1'b0));
        send_row(build_row('0, 1'b1, 1'b1, 1'b0));
        send_row(build_row(KEY_MIN, 1'b1, 1'b0, 1'b0));
        send_row(build_row(KEY_ONE, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_single_row_columns();
        send_row(build_row(KEY_ONE, 1'b1, 1'b0, 1'b1));
        send_row(build_row(KEY_MIN, 1'b0, 1'b0, 1'b1));
        send_row(build_row(KEY_MAX, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic run_random_columns(input logic desc, input int row_budget);
        int sent;
        int length;
        write_descending(desc);
        sent = 0;
        while (sent < row_budget)
        begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            for (int i = 0; i < length; i++)
                send_row(random_row(i == length - 1));
            sent += length;
            // hold the next column back now and then until this one has drained
            if ($urandom_range(0, 5) == 0)
                wait_for_drain();
        end
    endtask

    task automatic test_full_column();
        write_descending(1'($urandom_range(0, 1)));
        for (int i = 0; i < ROW_SLOTS; i++)
            send_row(random_row(i == ROW_SLOTS - 1));
    endtask

    // Rows past the last slot are dropped; the last row itself is always dropped
    task automatic test_overflow_column();
        int extra;
        write_descending(1'($urandom_range(0, 1)));
        extra = $urandom_range(1, 3);
        for (int i = 0; i < ROW_SLOTS + extra; i++)
            send_row(random_row(i == ROW_SLOTS + extra - 1));
    endtask

    task automatic test_unthrottled_columns();
        wait_for_drain();
        idling = 1'b0;
        run_random_columns(1'b1, 40);
    endtask

    // Receiver stall bursts
    initial
    begin
        int hold;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling && $urandom_range(0, 7) == 0)
            begin
                hold         = $urandom_range(1, 15);
                result_stall = 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            else
                result_stall = 1'b0;
        end
    end

    // Compare each result transaction with the oldest expected rank
    always @(posedge clk)
    begin
        crk_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_ranks.size() == 0)
            begin
                $error("unexpected result transaction: rank %0d", result_data.rank);
                mismatches++;
            end
            else
            begin
                want = expected_ranks.pop_front();
                if (result_data.rank !== want.rank)
                begin
                    $error("rank: expected %0d, got %0d", want.rank, result_data.rank);
                    mismatches++;
                end
                if (result_data.rank_present !== want.rank_present)
                begin
                    $error("rank_present: expected %0d, got %0d",
                           want.rank_present, result_data.rank_present);
                    mismatches++;
                end
                if (result_data.last_rank !== want.last_rank)
                begin
                    $error("last_rank: expected %0d, got %0d",
                           want.last_rank, result_data.last_rank);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        item_data       = '0;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        idling          = 1'b1;
        held_rows       = 0;
        rank_descending = 1'b0;
        mismatches      = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_ascending_extremes();
        test_descending_extremes();
        test_single_row_columns();
        run_random_columns(1'b0, 40);
        run_random_columns(1'b1, 40);
        test_full_column();
        run_random_columns(1'b0, 40);
        test_overflow_column();
        test_unthrottled_columns();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_ranks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/crk_pkg.sv
rtl/core/crk_front.sv
rtl/core/crk_queue.sv
rtl/core/crk_back.sv
rtl/core/competition_rank_engine.sv
bench/competition_rank_engine_test.sv
